### rtl/cbdot_pkg.sv
// ----------------------------------------------------------------------------
// cbdot_pkg: shared types and constants
// Widths, register indexes, the queue item type and the centroid lookup
// used by the codebook int8 dot product accumulator.
// ----------------------------------------------------------------------------
package cbdot_pkg;

  // Accumulator and result widths.
  localparam int ACC_WIDTH  = 32;
  localparam int OUT_WIDTH  = 32;

  // Payload widths.
  localparam int CODE_W     = 8;
  localparam int ACT_W      = 8;
  localparam int CENT_W     = 8;
  localparam int LANES      = 4;
  localparam int TERM_W     = CENT_W + ACT_W;
  localparam int TSUM_W     = TERM_W + 2;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CENT_WORDS = 4;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTROID_0 = 3'd0,
    REG_CENTROID_1 = 3'd1,
    REG_CENTROID_2 = 3'd2,
    REG_CENTROID_3 = 3'd3,
    REG_CODE_MODE  = 3'd4
  } cfg_reg_t;

  // Code packing modes.
  typedef enum logic {
    MODE_2BIT = 1'b0,
    MODE_4BIT = 1'b1
  } code_mode_t;

  // Four 32-bit words that hold the sixteen centroids.
  typedef logic [CENT_WORDS-1:0][CFG_DATA_W-1:0] centroid_table_t;

  // One classified item: a centroid and an activation for each lane.
  typedef struct packed {
    logic [LANES-1:0][CENT_W-1:0] cent;
    logic [LANES-1:0][ACT_W-1:0]  act;
    logic                         last;
  } cbdot_item_t;

  // Pick one signed byte of the centroid table.
  function automatic logic [CENT_W-1:0] centroid_lookup(centroid_table_t tbl,
                                                        logic [3:0] idx);
    logic [CFG_DATA_W-1:0] word;
    word = tbl[idx[3:2]];
    return word[{idx[1:0], 3'b000} +: CENT_W];
  endfunction

endpackage

### rtl/cbdot_front.sv
// ----------------------------------------------------------------------------
// cbdot_front: configuration and item classification
// Holds the centroid table and code mode, takes input requests, unpacks the
// code byte into per-lane centroids and hands the item to the queue.
// ----------------------------------------------------------------------------
module cbdot_front (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cbdot_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cbdot_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [cbdot_pkg::CODE_W-1:0]           code_byte,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_0,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_1,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_2,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_3,
  input  logic                                   group_end,
  // Push side of the queue.
  output logic                                   push_valid,
  output cbdot_pkg::cbdot_item_t                 push_item,
  input  logic                                   push_full
);
  import cbdot_pkg::*;

  centroid_table_t centroids;
  code_mode_t      code_mode;
  logic            front_valid;
  logic            front_valid_next;
  cbdot_item_t     front_item;
  cbdot_item_t     decoded;
  logic            load;
  logic            push;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centroids <= '0;
      code_mode <= MODE_2BIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTROID_0: centroids[0] <= cfg_data;
        REG_CENTROID_1: centroids[1] <= cfg_data;
        REG_CENTROID_2: centroids[2] <= cfg_data;
        REG_CENTROID_3: centroids[3] <= cfg_data;
        REG_CODE_MODE:  code_mode <= code_mode_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // Unpack the codes and look up one centroid per lane. In 4-bit mode the
  // upper two lanes carry a zero centroid so they add nothing.
  always_comb begin
    decoded.act  = {act_3, act_2, act_1, act_0};
    decoded.last = group_end;
    unique case (code_mode)
      MODE_4BIT: begin
        decoded.cent[0] = centroid_lookup(centroids, code_byte[3:0]);
        decoded.cent[1] = centroid_lookup(centroids, code_byte[7:4]);
        decoded.cent[2] = '0;
        decoded.cent[3] = '0;
      end
      default: begin
        decoded.cent[0] = centroid_lookup(centroids, {2'b00, code_byte[1:0]});
        decoded.cent[1] = centroid_lookup(centroids, {2'b00, code_byte[3:2]});
        decoded.cent[2] = centroid_lookup(centroids, {2'b00, code_byte[5:4]});
        decoded.cent[3] = centroid_lookup(centroids, {2'b00, code_byte[7:6]});
      end
    endcase
  end

  // The front register stalls only when it holds an item the queue refuses.
  assign in_stall   = front_valid && push_full;
  assign load       = in_valid && !in_stall;
  assign push       = front_valid && !push_full;
  assign push_valid = front_valid;
  assign push_item  = front_item;

  always_comb begin
    front_valid_next = front_valid;
    if (load) begin
      front_valid_next = 1'b1;
    end else if (push) begin
      front_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= front_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_item <= decoded;
    end
  end

endmodule

### rtl/cbdot_queue.sv
// ----------------------------------------------------------------------------
// cbdot_queue: short item queue
// A small first-in first-out buffer that decouples the front part from the
// multiply and accumulate part.
// ----------------------------------------------------------------------------
module cbdot_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push_valid,
  input  cbdot_pkg::cbdot_item_t push_item,
  output logic                   push_full,
  output logic                   pop_valid,
  output cbdot_pkg::cbdot_item_t pop_item,
  input  logic                   pop_ready
);
  import cbdot_pkg::*;

  cbdot_item_t            slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_CNT_W-1:0] count_next;
  logic                   do_push;
  logic                   do_pop;

  assign push_full = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_valid && pop_ready;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/cbdot_back.sv
// ----------------------------------------------------------------------------
// cbdot_back: multiply and accumulate
// Multiplies each lane's centroid by its activation, sums the lanes, adds
// the sum into the running total and emits the total at the end of a group.
// ----------------------------------------------------------------------------
module cbdot_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pop_valid,
  input  cbdot_pkg::cbdot_item_t                pop_item,
  output logic                                  pop_ready,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cbdot_pkg::OUT_WIDTH-1:0] dot_sum
);
  import cbdot_pkg::*;

  logic                        adv;
  logic signed [TERM_W-1:0]    prod [LANES];
  logic signed [TSUM_W-1:0]    lane_sum;
  logic                        a_valid;
  logic                        a_last;
  logic signed [TSUM_W-1:0]    a_sum;
  logic signed [ACC_WIDTH-1:0] acc;
  logic signed [ACC_WIDTH-1:0] acc_next;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv       = !out_valid || !out_stall;
  assign pop_ready = adv;

  // Lane products and their sum.
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      prod[i]  = signed'(pop_item.cent[i]) * signed'(pop_item.act[i]);
      lane_sum = lane_sum + TSUM_W'(prod[i]);
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sum  <= lane_sum;
      a_last <= pop_item.last;
    end
  end

  // Accumulate stage; the total wraps at the accumulator width.
  assign acc_next = acc + ACC_WIDTH'(a_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= a_valid && a_last;
      if (a_valid) begin
        acc <= a_last ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid && a_last) begin
      dot_sum <= OUT_WIDTH'(acc_next);
    end
  end

endmodule

### rtl/codebook_int8_dot_accumulate.sv
// ----------------------------------------------------------------------------
// codebook_int8_dot_accumulate: codebook int8 dot product accumulator
// Looks up packed weight codes in a sixteen-entry centroid table and
// accumulates their products with int8 activations over a group.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request carries a code byte,
//   four activations and group_end. A request is taken at a clock edge with
//   in_valid high and in_stall low. One request can be taken every cycle while in_stall stays low.
//   Output channel (out_valid / out_stall): one dot_sum per group, sent for
//   the request with group_end set; it holds until a cycle with out_stall low.
//   Configuration channel (cfg_valid / cfg_ready): writes the four centroid
//   words and the code mode; cfg_ready is always high. Write it only while
//   no group is in flight.
//   Path: the result of a group-end request goes through the front register,
//   a queue slot and the product stage, then the accumulate stage loads the
//   output register.
//   Throughput: one request per cycle while out_stall stays low. A stalled
//   output stops the back part; the four-entry queue and the front register
//   keep taking requests until they fill.
//   Reset: synchronous; clears the table, mode, total and all valid flags.
// ----------------------------------------------------------------------------
module codebook_int8_dot_accumulate (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [cbdot_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cbdot_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [cbdot_pkg::CODE_W-1:0]           code_byte,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_0,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_1,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_2,
  input  logic signed [cbdot_pkg::ACT_W-1:0]     act_3,
  input  logic                                   group_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [cbdot_pkg::OUT_WIDTH-1:0] dot_sum
);
  import cbdot_pkg::*;

  logic        push_valid;
  cbdot_item_t push_item;
  logic        push_full;
  logic        pop_valid;
  cbdot_item_t pop_item;
  logic        pop_ready;

  // Classification and configuration.
  cbdot_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_byte  (code_byte),
    .act_0      (act_0),
    .act_1      (act_1),
    .act_2      (act_2),
    .act_3      (act_3),
    .group_end  (group_end),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_full  (push_full)
  );

  // Decoupling queue.
  cbdot_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_full  (push_full),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // Multiply and accumulate.
  cbdot_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dot_sum    (dot_sum)
  );

endmodule

### rtl/cbdot_checker.sv
// ----------------------------------------------------------------------------
// cbdot_checker: port-level checks
// Watches the top-level ports for reset behavior, configuration readiness
// and a stable result while the receiver stalls.
// ----------------------------------------------------------------------------
module cbdot_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   cfg_ready,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [cbdot_pkg::OUT_WIDTH-1:0] dot_sum
);
  import cbdot_pkg::*;

  // Reset leaves no result pending and the input open.
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the output and input flow control");

  // The configuration channel never refuses a write.
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration write refused");

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dot_sum))
    else $error("result changed or dropped while stalled");

endmodule

bind codebook_int8_dot_accumulate cbdot_checker u_cbdot_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg_ready),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .dot_sum   (dot_sum)
);
